[rtl/core/apem_pkg.sv]
// Shared types, constants and helpers for the alternating power and energy meter.
package apem_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 32;
    localparam int SCALE_PRODUCT_W = SAMPLE_W + SCALE_W;
    localparam int OUT_W    = 48;
    localparam int STEP_W   = 7;
    localparam int REM_W    = 21;

    localparam logic [REM_W-1:0] SAMPLES_PER_HOUR = 21'd7200;
    localparam logic [REM_W-1:0] CHARGE_DIVISOR   = 21'd1843200;

    localparam logic [SCALE_W-1:0] AMPS_PER_COUNT_RESET  = 32'd1048576;
    localparam logic [SCALE_W-1:0] VOLTS_PER_COUNT_RESET = 32'd11534;

    localparam logic CFG_AMPS_PER_COUNT  = 1'b0;
    localparam logic CFG_VOLTS_PER_COUNT = 1'b1;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_REPORT = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample_count;
    } apem_req_t;

    typedef struct packed {
        logic signed [31:0]      current_q16;
        logic signed [31:0]      voltage_q16;
        logic signed [OUT_W-1:0] power_q16;
        logic signed [OUT_W-1:0] energy_wh_q16;
        logic signed [OUT_W-1:0] charge_ah_q16;
        logic                    report_valid;
    } apem_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_POWER,
        ST_DIV_E,
        ST_MUL_C,
        ST_DIV_C,
        ST_FINISH
    } apem_state_t;

    typedef struct packed {
        logic              start;
        logic              is_div;
        logic              signed_last;
        logic              long_div;
        logic [STEP_W-1:0] last_step;
    } apem_cmd_t;

    // Floor by 2^8 of a sample times a scale, saturated to signed 32 bits.
    function automatic logic [31:0] sat_scale(input logic [SCALE_PRODUCT_W-1:0] p);
        logic [8:0] top;
        top = p[SCALE_PRODUCT_W-1:SCALE_PRODUCT_W-9];
        if ((&top) || !(|top))
            return p[39:8];
        else if (p[SCALE_PRODUCT_W-1])
            return {1'b1, {31{1'b0}}};
        else
            return {1'b0, {31{1'b1}}};
    endfunction

endpackage

[rtl/core/apem_serial_unit.sv]
// Bit-serial shift-add multiplier and restoring divider by one of two fixed divisors.
module apem_serial_unit
    import apem_pkg::*;
#(
    parameter int PROD_W = 96
)(
    input  logic              clk,
    input  logic              rst_n,
    input  apem_cmd_t         cmd,
    input  logic [PROD_W-1:0] load_data,
    input  logic [SCALE_W-1:0] load_mplier,
    output logic              done,
    output logic [PROD_W-1:0] result
);

    logic              busy_reg;
    logic              done_reg;
    logic              is_div_reg;
    logic              signed_last_reg;
    logic              long_div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] shf_reg;
    logic [SCALE_W-1:0] mplier_reg;
    logic [REM_W-1:0]  rem_reg;

    logic              last;
    logic [PROD_W-1:0] addend;
    logic [PROD_W-1:0] acc_next;
    logic [REM_W-1:0]  divisor;
    logic [REM_W+1:0]  trial;
    logic              q_bit;
    logic [REM_W-1:0]  rem_next;

    always_comb
    begin
        last = (cnt_reg == '0);
        // The top bit of a signed multiplier carries negative weight.
        if (!mplier_reg[0])
            addend = '0;
        else if (signed_last_reg && last)
            addend = ~shf_reg + {{(PROD_W-1){1'b0}}, 1'b1};
        else
            addend = shf_reg;
        acc_next = acc_reg + addend;

        divisor  = long_div_reg ? CHARGE_DIVISOR : SAMPLES_PER_HOUR;
        trial    = {1'b0, rem_reg, shf_reg[PROD_W-1]} - {2'b00, divisor};
        q_bit    = ~trial[REM_W+1];
        rem_next = q_bit ? trial[REM_W-1:0] : {rem_reg[REM_W-2:0], shf_reg[PROD_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.last_step;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - {{(STEP_W-1){1'b0}}, 1'b1};
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            is_div_reg      <= cmd.is_div;
            signed_last_reg <= cmd.signed_last;
            long_div_reg    <= cmd.long_div;
            acc_reg         <= '0;
            shf_reg         <= load_data;
            mplier_reg      <= load_mplier;
            rem_reg         <= '0;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                rem_reg <= rem_next;
                shf_reg <= {shf_reg[PROD_W-2:0], q_bit};
            end
            else
            begin
                acc_reg    <= acc_next;
                shf_reg    <= {shf_reg[PROD_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[SCALE_W-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = is_div_reg ? shf_reg : acc_reg;

endmodule

[rtl/core/alternating_power_energy_meter_unit.sv]
// Top level of the alternating power and energy meter.
// A current sample takes one multiply, a voltage sample two multiplies, and a report a
// divide, a multiply and a divide, all run in the one bit-serial multiply/divide unit,
// one bit per cycle. One request is worked on at a time; the next is taken the cycle
// after the response is handed to the output register.
// Reset clears the accumulators and last values, selects the current channel first and
// loads the default scale registers.
module alternating_power_energy_meter_unit
    import apem_pkg::*;
#(
    parameter int ACC_WIDTH = 64
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  apem_req_t          req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output apem_rsp_t          rsp,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [SCALE_W-1:0] cfg_data
);

    localparam int PROD_W = ACC_WIDTH + SCALE_W;
    localparam int SUM_W  = ((ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W) + 1;

    apem_state_t state_reg, state_next;

    logic [SCALE_W-1:0]   amps_per_count_reg;
    logic [SCALE_W-1:0]   volts_per_count_reg;
    logic                 expect_current_reg;
    logic                 is_current_reg;
    logic                 is_report_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [31:0]          last_current_reg;
    logic [31:0]          last_voltage_reg;
    logic [OUT_W-1:0]     last_power_reg;
    logic [ACC_WIDTH-1:0] energy_sum_reg;
    logic [ACC_WIDTH-1:0] charge_sum_reg;
    logic [OUT_W-1:0]     energy_rpt_reg;
    logic [OUT_W-1:0]     charge_rpt_reg;
    logic                 rsp_valid_reg;
    apem_rsp_t            rsp_reg;

    apem_cmd_t            cmd;
    logic [PROD_W-1:0]    load_data;
    logic [SCALE_W-1:0]   load_mplier;
    logic                 done;
    logic [PROD_W-1:0]    result;

    logic                 req_take;
    logic                 rsp_load;
    logic [SCALE_W-1:0]   per_count;
    logic [31:0]          scaled;
    logic [OUT_W-1:0]     power_val;
    logic [ACC_WIDTH-1:0] energy_mag;
    logic [ACC_WIDTH-1:0] charge_mag;
    logic [ACC_WIDTH-1:0] charge_acc_next;
    logic [ACC_WIDTH-1:0] energy_acc_next;

    function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [SUM_W-1:0] s);
        logic [SUM_W-ACC_WIDTH:0] top;
        top = s[SUM_W-1:ACC_WIDTH-1];
        if ((&top) || !(|top))
            return s[ACC_WIDTH-1:0];
        else if (s[SUM_W-1])
            return {1'b1, {(ACC_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(ACC_WIDTH-1){1'b1}}};
    endfunction

    // Applies the sign to a quotient magnitude and saturates to 48-bit signed.
    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [PROD_W-1:0] q);
        logic big;
        big = |q[PROD_W-1:OUT_W];
        if (!neg)
            return (big || q[OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
        else if (big || (q[OUT_W-1] && (|q[OUT_W-2:0])))
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return ~q[OUT_W-1:0] + {{(OUT_W-1){1'b0}}, 1'b1};
    endfunction

    apem_serial_unit #(
        .PROD_W(PROD_W)
    ) u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_data  (load_data),
        .load_mplier(load_mplier),
        .done       (done),
        .result     (result)
    );

    always_comb
    begin
        req_take  = req_valid && (state_reg == ST_IDLE);
        rsp_load  = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);
        per_count = expect_current_reg ? amps_per_count_reg : volts_per_count_reg;
        scaled    = sat_scale(result[SCALE_PRODUCT_W-1:0]);
        power_val = result[63:16];

        energy_mag = energy_sum_reg[ACC_WIDTH-1]
            ? (~energy_sum_reg + {{(ACC_WIDTH-1){1'b0}}, 1'b1}) : energy_sum_reg;
        charge_mag = charge_sum_reg[ACC_WIDTH-1]
            ? (~charge_sum_reg + {{(ACC_WIDTH-1){1'b0}}, 1'b1}) : charge_sum_reg;

        charge_acc_next = sat_acc(
            {{(SUM_W-ACC_WIDTH){charge_sum_reg[ACC_WIDTH-1]}}, charge_sum_reg}
            + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg});
        energy_acc_next = sat_acc(
            {{(SUM_W-ACC_WIDTH){energy_sum_reg[ACC_WIDTH-1]}}, energy_sum_reg}
            + {{(SUM_W-OUT_W){power_val[OUT_W-1]}}, power_val});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = (req.action == ACTION_REPORT) ? ST_DIV_E : ST_SCALE;
            end
            ST_SCALE:
            begin
                if (done)
                    state_next = is_current_reg ? ST_FINISH : ST_POWER;
            end
            ST_POWER:
            begin
                if (done)
                    state_next = ST_FINISH;
            end
            ST_DIV_E:
            begin
                if (done)
                    state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                if (done)
                    state_next = ST_DIV_C;
            end
            ST_DIV_C:
            begin
                if (done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        load_data   = '0;
        load_mplier = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (req.action == ACTION_REPORT)
                    begin
                        cmd.is_div    = 1'b1;
                        cmd.last_step = STEP_W'(ACC_WIDTH - 1);
                        load_data     = {energy_mag, {SCALE_W{1'b0}}};
                    end
                    else
                    begin
                        cmd.signed_last = 1'b1;
                        cmd.last_step   = STEP_W'(SAMPLE_W - 1);
                        load_data       = {{(PROD_W-SCALE_W){1'b0}}, per_count};
                        load_mplier     = {{(SCALE_W-SAMPLE_W){1'b0}}, req.sample_count};
                    end
                end
            end
            ST_SCALE:
            begin
                if (done && !is_current_reg)
                begin
                    cmd.start       = 1'b1;
                    cmd.signed_last = 1'b1;
                    cmd.last_step   = STEP_W'(SCALE_W - 1);
                    load_data       = {{(PROD_W-32){last_current_reg[31]}}, last_current_reg};
                    load_mplier     = scaled;
                end
            end
            ST_DIV_E:
            begin
                if (done)
                begin
                    cmd.start     = 1'b1;
                    cmd.last_step = STEP_W'(SCALE_W - 1);
                    load_data     = {{SCALE_W{1'b0}}, charge_mag};
                    load_mplier   = amps_per_count_reg;
                end
            end
            ST_MUL_C:
            begin
                if (done)
                begin
                    cmd.start     = 1'b1;
                    cmd.is_div    = 1'b1;
                    cmd.long_div  = 1'b1;
                    cmd.last_step = STEP_W'(PROD_W - 1);
                    load_data     = result;
                end
            end
            ST_POWER, ST_DIV_C, ST_FINISH:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            amps_per_count_reg  <= AMPS_PER_COUNT_RESET;
            volts_per_count_reg <= VOLTS_PER_COUNT_RESET;
            expect_current_reg  <= 1'b1;
            last_current_reg    <= '0;
            last_voltage_reg    <= '0;
            last_power_reg      <= '0;
            energy_sum_reg      <= '0;
            charge_sum_reg      <= '0;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == CFG_AMPS_PER_COUNT)
                    amps_per_count_reg <= cfg_data;
                else
                    volts_per_count_reg <= cfg_data;
            end

            if (req_take && (req.action == ACTION_SAMPLE))
                expect_current_reg <= ~expect_current_reg;

            if ((state_reg == ST_SCALE) && done)
            begin
                if (is_current_reg)
                begin
                    last_current_reg <= scaled;
                    charge_sum_reg   <= charge_acc_next;
                end
                else
                begin
                    last_voltage_reg <= scaled;
                end
            end

            if ((state_reg == ST_POWER) && done)
            begin
                last_power_reg <= power_val;
                energy_sum_reg <= energy_acc_next;
            end

            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            is_current_reg <= expect_current_reg;
            is_report_reg  <= (req.action == ACTION_REPORT);
            sample_reg     <= req.sample_count;
        end

        if ((state_reg == ST_DIV_E) && done)
            energy_rpt_reg <= sat_out(energy_sum_reg[ACC_WIDTH-1], result);

        if ((state_reg == ST_DIV_C) && done)
            charge_rpt_reg <= sat_out(charge_sum_reg[ACC_WIDTH-1], result);

        if (rsp_load)
        begin
            rsp_reg.current_q16   <= last_current_reg;
            rsp_reg.voltage_q16   <= last_voltage_reg;
            rsp_reg.power_q16     <= last_power_reg;
            rsp_reg.energy_wh_q16 <= is_report_reg ? energy_rpt_reg : '0;
            rsp_reg.charge_ah_q16 <= is_report_reg ? charge_rpt_reg : '0;
            rsp_reg.report_valid  <= is_report_reg;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[dv/alternating_power_energy_meter_unit_test.sv]
// Self-checking testbench for the alternating power and energy meter unit.
`timescale 1ns / 1ps

module alternating_power_energy_meter_unit_test;
    import apem_pkg::*;

    localparam int ACC_W = 64;
    localparam logic [31:0] AMPS_DEFAULT  = 32'd1048576;
    localparam logic [31:0] VOLTS_DEFAULT = 32'd11534;
    localparam logic [63:0] HOUR_SAMPLES  = 64'd7200;
    localparam logic [127:0] CHARGE_DIV   = 128'd1843200;
    localparam int RANDOM_PER_PHASE = 250;

    typedef struct {
        bit          is_cfg;
        logic        cfg_sel;
        logic [31:0] cfg_val;
        apem_req_t   item;
        bit          typed;
        apem_rsp_t   want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    apem_req_t   req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    apem_rsp_t   rsp;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_AMPS_PER_COUNT;
    logic [31:0] cfg_data = '0;

    // Meter state as the block should hold it.
    logic [31:0]        amps_scale;
    logic [31:0]        volts_scale;
    bit                 want_current;
    logic signed [31:0] last_amps;
    logic signed [31:0] last_volts;
    logic signed [47:0] last_watts;
    longint             energy_acc;
    longint             charge_acc;

    apem_rsp_t pending_rsps[$];
    plan_row_t plan[$];
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        reqs_sent = 0;
    int        reports_sent = 0;
    int        rsps_checked = 0;
    int        mismatches = 0;

    alternating_power_energy_meter_unit #(
        .ACC_WIDTH(ACC_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Floor of sample * scale / 2^8, clamped to signed 32 bits.
    function automatic logic signed [31:0] to_q16(logic signed [15:0] s, logic [31:0] k);
        logic signed [48:0] p;
        p = s * $signed({1'b0, k});
        p = p >>> 8;
        if (p > 49'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (p < -49'sd2147483648)
            return 32'h8000_0000;
        return p[31:0];
    endfunction

    function automatic longint acc_add(longint acc, longint add);
        logic signed [64:0] s;
        logic signed [64:0] top;
        logic signed [64:0] bot;
        top = (65'sd1 <<< (ACC_W - 1)) - 65'sd1;
        bot = -top - 65'sd1;
        s = acc + add;
        if (s > top)
            return top[63:0];
        else if (s < bot)
            return bot[63:0];
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(longint x);
        logic [63:0] u;
        u = x;
        return (x < 0) ? (~u + 64'd1) : u;
    endfunction

    function automatic logic [47:0] sat48(bit neg, logic [127:0] mag);
        if (!neg)
            return (mag > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
        if (mag > 128'h8000_0000_0000)
            return 48'h8000_0000_0000;
        return ~mag[47:0] + 48'd1;
    endfunction

    function automatic void meter_reset();
        amps_scale = AMPS_DEFAULT;
        volts_scale = VOLTS_DEFAULT;
        want_current = 1'b1;
        last_amps = '0;
        last_volts = '0;
        last_watts = '0;
        energy_acc = 0;
        charge_acc = 0;
    endfunction

    function automatic apem_rsp_t meter_predict(apem_req_t r);
        apem_rsp_t          o;
        logic signed [63:0] prod;
        logic [127:0]       c_prod;
        logic [63:0]        e_quot;
        o = '0;
        if (r.action == ACTION_SAMPLE) begin
            if (want_current) begin
                last_amps = to_q16(r.sample_count, amps_scale);
                charge_acc = acc_add(charge_acc,
                                     {{48{r.sample_count[15]}}, r.sample_count});
            end else begin
                last_volts = to_q16(r.sample_count, volts_scale);
                prod = last_amps * last_volts;
                prod = prod >>> 16;
                last_watts = prod[47:0];
                energy_acc = acc_add(energy_acc, {{16{last_watts[47]}}, last_watts});
            end
            want_current = !want_current;
        end else begin
            e_quot = mag64(energy_acc) / HOUR_SAMPLES;
            o.energy_wh_q16 = sat48(energy_acc < 0, {64'd0, e_quot});
            c_prod = {64'd0, mag64(charge_acc)} * {96'd0, amps_scale};
            o.charge_ah_q16 = sat48(charge_acc < 0, c_prod / CHARGE_DIV);
            o.report_valid = 1'b1;
        end
        o.current_q16 = last_amps;
        o.voltage_q16 = last_volts;
        o.power_q16 = last_watts;
        return o;
    endfunction

    function automatic void note_mismatch(string field, logic signed [63:0] want,
                                          logic signed [63:0] got);
        mismatches++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    // Response side: compare against the oldest expectation, then pick the next stall.
    always @(posedge clk)
    begin
        apem_rsp_t w;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_rsps.size() == 0) begin
                note_mismatch("unexpected response", 0, 1);
            end else begin
                w = pending_rsps.pop_front();
                rsps_checked++;
                if (rsp.current_q16 !== w.current_q16)
                    note_mismatch("current_q16", w.current_q16, rsp.current_q16);
                if (rsp.voltage_q16 !== w.voltage_q16)
                    note_mismatch("voltage_q16", w.voltage_q16, rsp.voltage_q16);
                if (rsp.power_q16 !== w.power_q16)
                    note_mismatch("power_q16", w.power_q16, rsp.power_q16);
                if (rsp.energy_wh_q16 !== w.energy_wh_q16)
                    note_mismatch("energy_wh_q16", w.energy_wh_q16, rsp.energy_wh_q16);
                if (rsp.charge_ah_q16 !== w.charge_ah_q16)
                    note_mismatch("charge_ah_q16", w.charge_ah_q16, rsp.charge_ah_q16);
                if (rsp.report_valid !== w.report_valid)
                    note_mismatch("report_valid", w.report_valid, rsp.report_valid);
            end
        end
        rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_item(apem_req_t item, bit typed, apem_rsp_t want);
        apem_rsp_t p;
        while ($urandom_range(99) < src_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = meter_predict(item);
        pending_rsps.push_back(typed ? want : p);
        reqs_sent++;
        if (item.action == ACTION_REPORT)
            reports_sent++;
    endtask

    // Scale registers change only with the meter idle and nothing outstanding.
    task automatic write_scale(logic sel, logic [31:0] val);
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_AMPS_PER_COUNT)
            amps_scale = val;
        else
            volts_scale = val;
    endtask

    function automatic void add_item(logic act, logic [15:0] s);
        plan_row_t r;
        r = '{default: '0};
        r.item.action = act;
        r.item.sample_count = s;
        plan.push_back(r);
    endfunction

    function automatic void add_typed(logic act, logic [15:0] s, logic [31:0] amps,
                                      logic [47:0] watts, logic rv);
        plan_row_t r;
        r = '{default: '0};
        r.item.action = act;
        r.item.sample_count = s;
        r.typed = 1'b1;
        r.want.current_q16 = amps;
        r.want.power_q16 = watts;
        r.want.report_valid = rv;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(logic sel, logic [31:0] val);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_sel = sel;
        r.cfg_val = val;
        plan.push_back(r);
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(3))
            0: return $urandom_range(1 << 20);
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return 32'd0;
        endcase
    endfunction

    function automatic apem_req_t random_item();
        apem_req_t r;
        r.action = ($urandom_range(7) == 0) ? ACTION_REPORT : ACTION_SAMPLE;
        case ($urandom_range(7))
            0: r.sample_count = 16'h7FFF;
            1: r.sample_count = 16'h8000;
            2: r.sample_count = 16'($urandom_range(31) - 16);
            default: r.sample_count = 16'($urandom);
        endcase
        return r;
    endfunction

    initial
    begin
        int        idle_mix[4];
        int        stall_mix[4];
        apem_rsp_t unused;
        unused = '0;
        idle_mix = '{0, 63, 0, 32};
        stall_mix = '{0, 0, 63, 32};
        meter_reset();

        // Directed part: the default scales, then full scale (saturation), then zero, then the defaults again.
        add_typed(ACTION_REPORT, 16'h0000, 32'h0, 48'h0, 1'b1);
        add_typed(ACTION_SAMPLE, 16'h7FFF, 32'h07FF_F000, 48'h0, 1'b0);
        add_item(ACTION_REPORT, 16'hFFFF);
        add_item(ACTION_SAMPLE, 16'h8000);
        add_item(ACTION_SAMPLE, 16'h8000);
        add_item(ACTION_SAMPLE, 16'h7FFF);
        add_item(ACTION_SAMPLE, 16'hFFFF);
        add_item(ACTION_SAMPLE, 16'h0001);
        add_item(ACTION_SAMPLE, 16'h0000);
        add_item(ACTION_SAMPLE, 16'h0000);
        add_item(ACTION_REPORT, 16'h0000);
        add_cfg(CFG_AMPS_PER_COUNT, 32'hFFFF_FFFF);
        add_cfg(CFG_VOLTS_PER_COUNT, 32'hFFFF_FFFF);
        add_typed(ACTION_SAMPLE, 16'h7FFF, 32'h7FFF_FFFF, 48'h0, 1'b0);
        add_item(ACTION_SAMPLE, 16'h8000);
        add_item(ACTION_SAMPLE, 16'h8000);
        add_item(ACTION_SAMPLE, 16'h8000);
        add_item(ACTION_REPORT, 16'h0000);
        add_cfg(CFG_AMPS_PER_COUNT, 32'h0);
        add_cfg(CFG_VOLTS_PER_COUNT, 32'h0);
        add_item(ACTION_SAMPLE, 16'h1234);
        add_item(ACTION_SAMPLE, 16'h7FFF);
        add_item(ACTION_REPORT, 16'h0000);
        add_cfg(CFG_AMPS_PER_COUNT, AMPS_DEFAULT);
        add_cfg(CFG_VOLTS_PER_COUNT, VOLTS_DEFAULT);
        add_item(ACTION_SAMPLE, 16'h5555);
        add_item(ACTION_SAMPLE, 16'hAAAA);
        add_item(ACTION_REPORT, 16'h0000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 20;
        sink_stall_pct = 20;
        foreach (plan[k]) begin
            if (plan[k].is_cfg)
                write_scale(plan[k].cfg_sel, plan[k].cfg_val);
            else
                send_item(plan[k].item, plan[k].typed, plan[k].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            write_scale(CFG_AMPS_PER_COUNT, pick_scale());
            write_scale(CFG_VOLTS_PER_COUNT, pick_scale());
            src_idle_pct = idle_mix[ph];
            sink_stall_pct = stall_mix[ph];
            repeat (RANDOM_PER_PHASE)
                send_item(random_item(), 1'b0, unused);
        end

        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (2 * ACC_W + 80) @(posedge clk);

        $display("Sent %0d requests (%0d reports) over four traffic phases and several scales;",
                 reqs_sent, reports_sent);
        $display("checked %0d responses, %0d field mismatches.", rsps_checked, mismatches);
        if (mismatches == 0 && pending_rsps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
